@@ hw/rtl/ple_pkg.sv @@
`timescale 1ns / 1ps
package ple_pkg;

  // Highest loop number that still gets coded.
  localparam int MAX_CODED_INDEX = 63;

  // Width of a position number: up to MAX_CODED_INDEX + 1.
  localparam int POS_W = $clog2(MAX_CODED_INDEX + 2);

  localparam int QUEUE_DEPTH = 2;
  localparam int QIDX_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // Input kinds
  localparam logic KIND_HEADER  = 1'b0;
  localparam logic KIND_PAYLOAD = 1'b1;

  // Slot codes
  localparam logic [1:0] SLOT_POS   = 2'd0;
  localparam logic [1:0] SLOT_DATA  = 2'd1;
  localparam logic [1:0] SLOT_CHECK = 2'd2;

  // One queue entry: up to two coded bytes caused by one item.
  typedef struct packed {
    logic             v0;
    logic [7:0]       b0;
    logic [POS_W-1:0] p0;
    logic             v1;
    logic [7:0]       b1;
    logic [POS_W-1:0] p1;
  } ple_entry_t;

  typedef struct packed {
    logic full;
    logic empty;
  } ple_qstat_t;

  // Symbol for one slot of a coded byte.
  function automatic logic [7:0] ple_symbol(input logic [7:0] data,
                                            input logic [POS_W-1:0] pos,
                                            input logic [1:0] slot);
    logic [7:0] pos8;
    logic [7:0] position;
    logic [7:0] d;
    logic [7:0] res;
    pos8     = 8'(pos);
    position = (data > 8'd128) ? pos8 + 8'd64 : pos8;
    d        = (data < 8'd128) ? data + 8'd128 : data;
    case (slot)
      SLOT_POS:  res = position;
      SLOT_DATA: res = d;
      default:   res = 8'h80 | ((position ^ d) & 8'h7f);
    endcase
    return res;
  endfunction

endpackage

@@ hw/rtl/ple_in_if.sv @@
`timescale 1ns / 1ps
interface ple_in_if;
  logic       valid;
  logic       ready;
  logic       kind;
  logic [7:0] value;

  modport source (output valid, output kind, output value, input ready);
  modport sink   (input valid, input kind, input value, output ready);
endinterface

@@ hw/rtl/ple_out_if.sv @@
`timescale 1ns / 1ps
interface ple_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] symbol;
  logic [1:0] slot;
  logic       last;

  modport source (output valid, output symbol, output slot, output last, input ready);
  modport sink   (input valid, input symbol, input slot, input last, output ready);
endinterface

@@ hw/rtl/packet_length_symbol_encoder_top.sv @@
`timescale 1ns / 1ps
// Packet-length symbol encoder. Each item on "frame" is a header (kind 0, value =
// total frame length including the checksum byte) or a payload byte (kind 1).
// Every coded byte leaves on "symbols" as three items: position, data and check
// symbol (slot 0, 1, 2); last marks the final symbol caused by one input item.
// A header is coded at position 1, payload byte j at position j+2, and once the
// frame's last payload byte arrives the XOR checksum follows at position L+1.
// Positions beyond the coding limit emit nothing; payload outside a frame is
// dropped. Rate: one symbol per cycle on the output while the receiver is ready;
// the single output channel limits throughput. The front end takes an item in
// any cycle the two-entry queue has room, so input and output stall
// independently; an item's symbols follow it through the queue and the back
// end's entry register.
module packet_length_symbol_encoder_top (
  input  logic      clk,
  input  logic      rst,
  ple_in_if.sink    frame,
  ple_out_if.source symbols
);
  import ple_pkg::*;

  ple_entry_t wr_entry;
  ple_entry_t rd_entry;
  ple_qstat_t qstat;
  logic       push;
  logic       pop;

  // front: accept, track the frame, build coded-byte entries
  ple_front u_front (
    .clk   (clk),
    .rst   (rst),
    .frame (frame),
    .qstat (qstat),
    .push  (push),
    .entry (wr_entry)
  );

  // decoupling queue
  ple_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .wr_entry (wr_entry),
    .pop      (pop),
    .rd_entry (rd_entry),
    .qstat    (qstat)
  );

  // back: expand each entry into symbols
  ple_back u_back (
    .clk      (clk),
    .rst      (rst),
    .qstat    (qstat),
    .rd_entry (rd_entry),
    .pop      (pop),
    .symbols  (symbols)
  );

endmodule

@@ hw/rtl/ple_front.sv @@
`timescale 1ns / 1ps
module ple_front (
  input  logic                clk,
  input  logic                rst,
  ple_in_if.sink              frame,
  input  ple_pkg::ple_qstat_t qstat,
  output logic                push,
  output ple_pkg::ple_entry_t entry
);
  import ple_pkg::*;

  localparam logic [8:0] MAX_IDX = 9'(MAX_CODED_INDEX);

  logic [7:0] byte_index, byte_index_next;
  logic [7:0] frame_length, frame_length_next;
  logic [7:0] xor_sum, xor_sum_next;
  logic       frame_open, frame_open_next;
  logic       acc;

  assign frame.ready = !qstat.full;
  assign acc         = frame.valid && frame.ready;

  always_comb begin
    byte_index_next   = byte_index;
    frame_length_next = frame_length;
    xor_sum_next      = xor_sum;
    frame_open_next   = frame_open;
    entry             = '0;
    if (frame.kind == KIND_HEADER) begin
      entry.v0          = 1'b1;
      entry.b0          = frame.value;
      entry.p0          = POS_W'(1);
      frame_length_next = frame.value;
      byte_index_next   = '0;
      xor_sum_next      = '0;
      frame_open_next   = (frame.value != 8'd0);
      // length one: checksum (zero) follows at once
      if (frame.value == 8'd1) begin
        entry.v1        = 1'b1;
        entry.b1        = 8'd0;
        entry.p1        = POS_W'(2);
        frame_open_next = 1'b0;
      end
    end else if (frame_open) begin
      if ({1'b0, byte_index} + 9'd1 <= MAX_IDX) begin
        entry.v0 = 1'b1;
        entry.b0 = frame.value;
        entry.p0 = byte_index[POS_W-1:0] + POS_W'(2);
      end
      xor_sum_next    = xor_sum ^ frame.value;
      byte_index_next = byte_index + 8'd1;
      if ({1'b0, byte_index_next} + 9'd1 >= {1'b0, frame_length}) begin
        frame_open_next = 1'b0;
        if ({1'b0, frame_length} <= MAX_IDX) begin
          entry.v1 = 1'b1;
          entry.b1 = xor_sum_next;
          entry.p1 = frame_length[POS_W-1:0] + POS_W'(1);
        end
      end
    end
  end

  assign push = acc && (entry.v0 || entry.v1);

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_index   <= '0;
      frame_length <= '0;
      xor_sum      <= '0;
      frame_open   <= 1'b0;
    end else if (acc) begin
      byte_index   <= byte_index_next;
      frame_length <= frame_length_next;
      xor_sum      <= xor_sum_next;
      frame_open   <= frame_open_next;
    end
  end

`ifndef SYNTHESIS
  // an open frame always has its checksum still ahead
  a_open_bound: assert property (@(posedge clk) disable iff (rst)
    frame_open |-> ({1'b0, byte_index} + 9'd1 < {1'b0, frame_length}))
    else $error("open frame past its length");

  // payload outside a frame produces nothing
  a_no_orphan: assert property (@(posedge clk) disable iff (rst)
    (acc && frame.kind == KIND_PAYLOAD && !frame_open) |-> !push)
    else $error("orphan payload queued");
`endif
endmodule

@@ hw/rtl/ple_queue.sv @@
`timescale 1ns / 1ps
module ple_queue (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  ple_pkg::ple_entry_t wr_entry,
  input  logic                pop,
  output ple_pkg::ple_entry_t rd_entry,
  output ple_pkg::ple_qstat_t qstat
);
  import ple_pkg::*;

  ple_entry_t        mem [QUEUE_DEPTH];
  logic [QIDX_W-1:0] wptr;
  logic [QIDX_W-1:0] rptr;
  logic [QCNT_W-1:0] count;

  assign qstat.full  = (count == QCNT_W'(QUEUE_DEPTH));
  assign qstat.empty = (count == '0);
  assign rd_entry    = mem[rptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wptr] <= wr_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wptr <= (wptr == QIDX_W'(QUEUE_DEPTH - 1)) ? '0 : wptr + QIDX_W'(1);
      end
      if (pop) begin
        rptr <= (rptr == QIDX_W'(QUEUE_DEPTH - 1)) ? '0 : rptr + QIDX_W'(1);
      end
      case ({push, pop})
        2'b10:   count <= count + QCNT_W'(1);
        2'b01:   count <= count - QCNT_W'(1);
        default: count <= count;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    !(push && qstat.full && !pop) && !(pop && qstat.empty))
    else $error("queue overflow or underflow");
`endif
endmodule

@@ hw/rtl/ple_back.sv @@
`timescale 1ns / 1ps
module ple_back (
  input  logic                clk,
  input  logic                rst,
  input  ple_pkg::ple_qstat_t qstat,
  input  ple_pkg::ple_entry_t rd_entry,
  output logic                pop,
  ple_out_if.source           symbols
);
  import ple_pkg::*;

  ple_entry_t       cur;
  logic             busy;
  logic             sel;
  logic [1:0]       phase;
  logic [7:0]       cur_byte;
  logic [POS_W-1:0] cur_pos;
  logic             fire;
  logic             last_sym;

  assign cur_byte = sel ? cur.b1 : cur.b0;
  assign cur_pos  = sel ? cur.p1 : cur.p0;
  assign last_sym = (phase == SLOT_CHECK) && (sel || !cur.v1);
  assign fire     = symbols.valid && symbols.ready;

  assign symbols.valid  = busy;
  assign symbols.symbol = ple_symbol(cur_byte, cur_pos, phase);
  assign symbols.slot   = phase;
  assign symbols.last   = last_sym;

  assign pop = (!busy || (fire && last_sym)) && !qstat.empty;

  always_ff @(posedge clk) begin
    if (pop) begin
      cur <= rd_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      sel   <= 1'b0;
      phase <= SLOT_POS;
    end else if (pop) begin
      busy  <= 1'b1;
      sel   <= !rd_entry.v0;
      phase <= SLOT_POS;
    end else if (fire) begin
      if (phase != SLOT_CHECK) begin
        phase <= phase + 2'd1;
      end else if (!last_sym) begin
        sel   <= 1'b1;
        phase <= SLOT_POS;
      end else begin
        busy <= 1'b0;
      end
    end
  end

`ifndef SYNTHESIS
  a_entry_nonempty: assert property (@(posedge clk) disable iff (rst)
    busy |-> (sel ? cur.v1 : cur.v0))
    else $error("emitting from an empty slot");

  a_phase_range: assert property (@(posedge clk) disable iff (rst)
    busy |-> (phase == SLOT_POS || phase == SLOT_DATA || phase == SLOT_CHECK))
    else $error("bad phase");
`endif
endmodule

@@ tb/packet_length_symbol_encoder_top_test.sv @@
`timescale 1ns / 1ps
module packet_length_symbol_encoder_top_test;
  import ple_pkg::*;

  // Receiver hold-off length for the back-pressure test, in cycles.
  localparam int HOLD_CYCLES  = 80;
  // Cycles allowed for outstanding symbols to drain.
  localparam int DRAIN_LIMIT  = 20000;
  // Quiet cycles after the last symbol.
  localparam int TAIL_CYCLES  = 20;
  // Reported mismatches; later ones are only counted.
  localparam int REPORT_LIMIT = 10;

  // One symbol as it leaves the block.
  typedef struct packed {
    logic [7:0] symbol;
    logic [1:0] slot;
    logic       last;
  } symbol_item_t;

  logic clk;
  logic rst;

  ple_in_if  frame_bus ();
  ple_out_if symbol_bus ();

  packet_length_symbol_encoder_top i_dut (
    .clk     (clk),
    .rst     (rst),
    .frame   (frame_bus),
    .symbols (symbol_bus)
  );

  // Symbols still owed by the block, oldest first.
  symbol_item_t expected_symbols[$];

  // Predictor state: mirrors the encoder's frame tracking.
  logic [7:0] payload_count = 8'd0;
  logic [7:0] frame_len     = 8'd0;
  logic [7:0] running_xor   = 8'd0;
  logic       frame_active  = 1'b0;

  int fail_count    = 0;
  int coded_items   = 0;  // accepted items that were not dropped
  int burst_left    = 0;  // items left in the current sender burst
  bit steady_send   = 1'b0; // keep the sender in one unbroken burst
  int hold_requests = 0;  // bumped to ask the receiver for a long hold-off

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // ------------------------------------------------------------------
  // Predictor
  // ------------------------------------------------------------------

  // Three symbols for one coded byte at a given position number.
  // Bytes above 128 move the position up by 64, bytes below 128 get the
  // top bit set on the data symbol; exactly 128 gets neither.
  function automatic void code_byte(input logic [7:0] data, input logic [7:0] pos);
    logic [7:0] position;
    logic [7:0] data_sym;
    position = (data > 8'd128) ? pos + 8'd64 : pos;
    data_sym = (data < 8'd128) ? data + 8'd128 : data;
    expected_symbols.push_back(symbol_item_t'{position, SLOT_POS, 1'b0});
    expected_symbols.push_back(symbol_item_t'{data_sym, SLOT_DATA, 1'b0});
    expected_symbols.push_back(
      symbol_item_t'{8'h80 | ((position ^ data_sym) & 8'h7f), SLOT_CHECK, 1'b0});
  endfunction

  // Once the final payload byte is in, the checksum follows at position L+1,
  // unless L is past the coding limit.
  function automatic void close_frame_if_done();
    if (frame_active && int'(payload_count) + 1 >= int'(frame_len)) begin
      if (int'(frame_len) <= MAX_CODED_INDEX)
        code_byte(running_xor, frame_len + 8'd1);
      frame_active = 1'b0;
    end
  endfunction

  // Works out the symbols one accepted item causes. Returns 0 for an item
  // the block drops (payload with no open frame).
  function automatic bit predict_item(input logic kind, input logic [7:0] value);
    int n_before;
    n_before = expected_symbols.size();
    if (kind == KIND_HEADER) begin
      code_byte(value, 8'd1);
      frame_len     = value;
      payload_count = 8'd0;
      running_xor   = 8'd0;
      frame_active  = (value != 8'd0);
      close_frame_if_done();
    end else begin
      if (!frame_active)
        return 1'b0;
      if (int'(payload_count) + 1 <= MAX_CODED_INDEX)
        code_byte(value, payload_count + 8'd2);
      running_xor   = running_xor ^ value;
      payload_count = payload_count + 8'd1;
      close_frame_if_done();
    end
    if (expected_symbols.size() > n_before)
      expected_symbols[expected_symbols.size() - 1].last = 1'b1;
    return 1'b1;
  endfunction

  function automatic void note_failure(input string msg);
    fail_count++;
    if (fail_count <= REPORT_LIMIT)
      $display("[%0t] ERROR: %s", $realtime, msg);
  endfunction

  // ------------------------------------------------------------------
  // Sender side
  // ------------------------------------------------------------------

  // Offers one item and waits for it to be taken. Between bursts the valid
  // line drops for a random gap; inside a burst it stays high from item to
  // item.
  task automatic send_item(input logic kind, input logic [7:0] value);
    int gap;
    if (!steady_send && burst_left <= 0) begin
      frame_bus.valid <= 1'b0;
      gap = $urandom_range(1, 7);
      repeat (gap) @(posedge clk);
      // Mostly short bursts, now and then a long run with no gaps.
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 80)
                                               : $urandom_range(1, 8);
    end
    frame_bus.valid <= 1'b1;
    frame_bus.kind  <= kind;
    frame_bus.value <= value;
    do @(posedge clk); while (frame_bus.ready !== 1'b1);
    if (predict_item(kind, value))
      coded_items++;
    burst_left--;
  endtask

  task automatic send_payload_run(input int count);
    int i;
    for (i = 0; i < count; i++)
      send_item(KIND_PAYLOAD, 8'($urandom_range(0, 255)));
  endtask

  // Drops valid and waits (with a cap) until no symbol is outstanding.
  // At least one edge passes, so valid never falls and rises in one step.
  task automatic drain_symbols();
    int waited;
    waited = 0;
    frame_bus.valid <= 1'b0;
    burst_left = 0;
    do begin
      @(posedge clk);
      waited++;
    end while (expected_symbols.size() != 0 && waited < DRAIN_LIMIT);
  endtask

  // ------------------------------------------------------------------
  // Receiver side: ready pattern and result checking
  // ------------------------------------------------------------------

  // Ready follows a random mode that is redrawn when its phase runs out: always ready,
  // coin flip, one cycle in three, or mostly ready. A hold request overrides
  // it with a long all-low stretch counted here.
  initial begin
    int mode;
    int phase_left;
    int tick;
    int hold_left;
    int hold_seen;
    mode       = 0;
    phase_left = 0;
    tick       = 0;
    hold_left  = 0;
    hold_seen  = 0;
    symbol_bus.ready <= 1'b0;
    forever begin
      @(posedge clk);
      tick++;
      if (hold_requests != hold_seen) begin
        hold_seen = hold_requests;
        hold_left = HOLD_CYCLES;
      end
      if (phase_left <= 0) begin
        mode       = $urandom_range(0, 3);
        phase_left = $urandom_range(10, 60);
      end
      phase_left--;
      if (hold_left > 0) begin
        hold_left--;
        symbol_bus.ready <= 1'b0;
      end else begin
        case (mode)
          0: begin
            symbol_bus.ready <= 1'b1;
          end
          1: begin
            symbol_bus.ready <= 1'($urandom_range(0, 1));
          end
          2: begin
            symbol_bus.ready <= (tick % 3 == 0);
          end
          default: begin
            symbol_bus.ready <= ($urandom_range(0, 4) != 0);
          end
        endcase
      end
    end
  end

  // Each symbol taken is matched against the oldest one owed.
  initial begin
    symbol_item_t got;
    symbol_item_t want;
    forever begin
      @(posedge clk);
      if (!rst && symbol_bus.valid === 1'b1 && symbol_bus.ready === 1'b1) begin
        got = symbol_item_t'{symbol_bus.symbol, symbol_bus.slot, symbol_bus.last};
        if (expected_symbols.size() == 0) begin
          note_failure($sformatf("unexpected symbol=%0d slot=%0d last=%0b",
                                 got.symbol, got.slot, got.last));
        end else begin
          want = expected_symbols.pop_front();
          if (got.symbol !== want.symbol || got.slot !== want.slot ||
              got.last !== want.last)
            note_failure($sformatf(
              "mismatch: expected symbol=%0d slot=%0d last=%0b, got symbol=%0d slot=%0d last=%0b",
              want.symbol, want.slot, want.last, got.symbol, got.slot, got.last));
        end
      end
    end
  end

  // ------------------------------------------------------------------
  // Tests
  // ------------------------------------------------------------------

  // Header extremes: max length opens a frame, length 64 replaces it and is
  // abandoned in turn, length 0 codes the header and opens nothing,
  // length 1 is followed at once by a zero checksum. A payload with no frame
  // open is dropped.
  task automatic test_header_extremes();
    send_item(KIND_HEADER, 8'd255);
    send_item(KIND_HEADER, 8'd64);
    send_item(KIND_HEADER, 8'd0);
    send_item(KIND_PAYLOAD, 8'h5a);
    send_item(KIND_HEADER, 8'd1);
    send_item(KIND_PAYLOAD, 8'hff);
  endtask

  // Bytes around the 128 threshold: 128 itself gets no flag on either side.
  task automatic test_value_thresholds();
    send_item(KIND_HEADER, 8'd7);
    send_item(KIND_PAYLOAD, 8'd0);
    send_item(KIND_PAYLOAD, 8'd127);
    send_item(KIND_PAYLOAD, 8'd128);
    send_item(KIND_PAYLOAD, 8'd129);
    send_item(KIND_PAYLOAD, 8'd255);
    send_item(KIND_PAYLOAD, 8'd128);  // closes the frame, checksum follows
  endtask

  // A header mid-frame abandons the open frame; surplus bytes are dropped.
  task automatic test_frame_abandon();
    send_item(KIND_HEADER, 8'd10);
    send_item(KIND_PAYLOAD, 8'h55);
    send_item(KIND_PAYLOAD, 8'h0f);
    send_item(KIND_HEADER, 8'd2);
    send_item(KIND_PAYLOAD, 8'haa);
    send_item(KIND_PAYLOAD, 8'h01);
    send_item(KIND_PAYLOAD, 8'h80);
  endtask

  // Frames that reach the coding limit. Length 63: every byte coded, the
  // checksum lands at the top position. Length 66: the last bytes and the
  // checksum are past the limit and code nothing, yet still count.
  task automatic test_long_frames();
    send_item(KIND_HEADER, 8'd63);
    send_payload_run(62);
    send_item(KIND_HEADER, 8'd66);
    send_payload_run(65);
    drain_symbols();
  endtask

  // Receiver holds off for a long stretch while the sender offers a frame
  // back to back, so the block fills and stalls its input; then the sender
  // waits for every symbol to come out, then sends a short frame and drains.
  task automatic test_backpressure();
    drain_symbols();
    steady_send = 1'b1;
    hold_requests++;
    send_item(KIND_HEADER, 8'd20);
    send_payload_run(19);
    steady_send = 1'b0;
    drain_symbols();
    send_item(KIND_HEADER, 8'd4);
    send_payload_run(3);
    drain_symbols();
  endtask

  // Mostly well-formed short frames with random content; the rest are cut
  // short, random header lengths, and stray payload with no frame open.
  task automatic test_random_frames(input int item_goal);
    int start_count;
    int pick;
    int len;
    int i;
    logic [7:0] byte_val;
    start_count = coded_items;
    while (coded_items - start_count < item_goal) begin
      pick = $urandom_range(0, 9);
      if (pick < 7) begin
        len = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 2) : $urandom_range(1, 10);
        send_item(KIND_HEADER, 8'(len));
        for (i = 1; i < len; i++) begin
          case ($urandom_range(0, 7))
            0:       byte_val = 8'd128;
            1:       byte_val = 8'd127;
            2:       byte_val = 8'd129;
            default: byte_val = 8'($urandom_range(0, 255));
          endcase
          send_item(KIND_PAYLOAD, byte_val);
        end
      end else if (pick == 7) begin
        // Cut short: the next header abandons this frame.
        len = $urandom_range(3, 12);
        send_item(KIND_HEADER, 8'(len));
        send_payload_run($urandom_range(0, len - 2));
      end else if (pick == 8) begin
        // Stray bytes; close any open frame first so they are dropped.
        if (frame_active)
          send_item(KIND_HEADER, 8'd0);
        send_payload_run($urandom_range(1, 3));
      end else begin
        send_item(KIND_HEADER, 8'($urandom_range(0, 255)));
        send_payload_run($urandom_range(0, 3));
      end
    end
  endtask

  // Run limit, far beyond the slowest correct run.
  initial begin
    #1_000_000;
    $display("Regression FAIL");
    $finish;
  end

  initial begin
    rst             <= 1'b1;
    frame_bus.valid <= 1'b0;
    frame_bus.kind  <= KIND_HEADER;
    frame_bus.value <= 8'd0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    test_header_extremes();
    test_value_thresholds();
    test_frame_abandon();
    test_long_frames();
    test_backpressure();
    test_random_frames(180);

    drain_symbols();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (expected_symbols.size() != 0)
      note_failure($sformatf("%0d symbols never arrived", expected_symbols.size()));
    if (fail_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
